FILE: rtl/core/wcts_pkg.sv
// ----------------------------------------------------------------------------
// wcts_pkg: shared types and constants for the wall column texture setup
// Field widths, texture and register codes, and the item record that
// moves from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package wcts_pkg;

    // Parameter defaults for the top level
    localparam int SCREEN_ROWS_DEFAULT = 480;
    localparam int FRAC_BITS_DEFAULT   = 16;

    // Field widths
    localparam int POS_W     = 24;
    localparam int DIR_W     = 18;
    localparam int DIST_W    = 24;
    localparam int TEX_W     = 13;
    localparam int SEL_W     = 2;
    localparam int COL_W     = 12;
    localparam int WH_W      = 16;
    localparam int LINE_W    = 12;
    localparam int STEP_W    = 28;
    localparam int CFG_IDX_W = 4;

    localparam int TEX_COUNT = 4;
    localparam logic [TEX_W-1:0] TEX_RESET = 13'd64;

    // Entries between front end and back end
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [SEL_W-1:0] {
        TEX_NORTH = 2'd0,
        TEX_SOUTH = 2'd1,
        TEX_WEST  = 2'd2,
        TEX_EAST  = 2'd3
    } tex_sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORTH_WIDTH  = 4'd0,
        REG_NORTH_HEIGHT = 4'd1,
        REG_SOUTH_WIDTH  = 4'd2,
        REG_SOUTH_HEIGHT = 4'd3,
        REG_WEST_WIDTH   = 4'd4,
        REG_WEST_HEIGHT  = 4'd5,
        REG_EAST_WIDTH   = 4'd6,
        REG_EAST_HEIGHT  = 4'd7
    } cfg_reg_t;

    // Classified column, ready for the arithmetic
    typedef struct packed {
        tex_sel_t                  sel;
        logic [TEX_W-1:0]          tex_w;
        logic [TEX_W-1:0]          tex_h;
        logic [POS_W-1:0]          pos;
        logic signed [DIR_W-1:0]   dir;
        logic [DIST_W-1:0]         depth;
    } front_item_t;

endpackage

FILE: rtl/core/wcts_if.sv
// ----------------------------------------------------------------------------
// wcts_if: channel interfaces of the wall column texture setup
// Ray input channel, wall result channel and register write channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface wcts_ray_if import wcts_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      hit_horiz;
    logic                      step_x_positive;
    logic                      step_y_positive;
    logic [POS_W-1:0]          player_x;
    logic [POS_W-1:0]          player_y;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic [DIST_W-1:0]         ray_depth;

    modport source (
        output valid, hit_horiz, step_x_positive, step_y_positive,
               player_x, player_y, dir_x, dir_y, ray_depth,
        input  ready
    );
    modport sink (
        input  valid, hit_horiz, step_x_positive, step_y_positive,
               player_x, player_y, dir_x, dir_y, ray_depth,
        output ready
    );
endinterface

interface wcts_wall_if import wcts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SEL_W-1:0]    texture_select;
    logic [COL_W-1:0]    tex_column;
    logic [WH_W-1:0]     column_height;
    logic [LINE_W-1:0]   span_top;
    logic [LINE_W-1:0]   span_bottom;
    logic [STEP_W-1:0]   texel_step;
    logic [STEP_W-1:0]   tex_row_start;
    logic                zero_height;

    modport source (
        output valid, texture_select, tex_column, column_height, span_top,
               span_bottom, texel_step, tex_row_start, zero_height,
        input  ready
    );
    modport sink (
        input  valid, texture_select, tex_column, column_height, span_top,
               span_bottom, texel_step, tex_row_start, zero_height,
        output ready
    );
endinterface

interface wcts_cfg_if import wcts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [TEX_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/wcts_front.sv
// ----------------------------------------------------------------------------
// wcts_front: front end of the wall column texture setup
// Holds the texture size registers, takes ray beats, picks the wall
// texture and the hit axis, and registers the classified column.
// ----------------------------------------------------------------------------
module wcts_front import wcts_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    wcts_ray_if.sink      ray,
    wcts_cfg_if.sink      cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output front_item_t   push_item
);

    logic [TEX_W-1:0] width_reg  [TEX_COUNT];
    logic [TEX_W-1:0] height_reg [TEX_COUNT];
    tex_sel_t         sel;
    front_item_t      item_next;
    front_item_t      item_reg;
    logic             valid_reg;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TEX_COUNT; i++)
            begin
                width_reg[i]  <= TEX_RESET;
                height_reg[i] <= TEX_RESET;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_NORTH_WIDTH:  width_reg[TEX_NORTH]  <= cfg.data;
                REG_NORTH_HEIGHT: height_reg[TEX_NORTH] <= cfg.data;
                REG_SOUTH_WIDTH:  width_reg[TEX_SOUTH]  <= cfg.data;
                REG_SOUTH_HEIGHT: height_reg[TEX_SOUTH] <= cfg.data;
                REG_WEST_WIDTH:   width_reg[TEX_WEST]   <= cfg.data;
                REG_WEST_HEIGHT:  height_reg[TEX_WEST]  <= cfg.data;
                REG_EAST_WIDTH:   width_reg[TEX_EAST]   <= cfg.data;
                REG_EAST_HEIGHT:  height_reg[TEX_EAST]  <= cfg.data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Texture choice: vertical line hit -> east/west, else south/north
    always_comb
    begin
        if (ray.hit_horiz)
            sel = ray.step_y_positive ? TEX_SOUTH : TEX_NORTH;
        else
            sel = ray.step_x_positive ? TEX_EAST : TEX_WEST;
    end

    // Hit axis: vertical line hit runs along y
    always_comb
    begin
        item_next.sel   = sel;
        item_next.tex_w = width_reg[sel];
        item_next.tex_h = height_reg[sel];
        item_next.pos   = ray.hit_horiz ? ray.player_x : ray.player_y;
        item_next.dir   = ray.hit_horiz ? ray.dir_x : ray.dir_y;
        item_next.depth = ray.ray_depth;
    end

    // Single holding stage toward the queue
    assign ray.ready = !valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ray.ready)
            valid_reg <= ray.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ray.valid && ray.ready)
            item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

FILE: rtl/core/wcts_queue.sv
// ----------------------------------------------------------------------------
// wcts_queue: short FIFO between front end and back end
// Lets the front end keep taking beats while the back end is stalled.
// Full is known from its own count, so no ready path runs through it.
// ----------------------------------------------------------------------------
module wcts_queue import wcts_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  front_item_t   push_item,
    output logic          pop_valid,
    input  logic          pop,
    output front_item_t   pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    front_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/core/wcts_div.sv
// ----------------------------------------------------------------------------
// wcts_div: pipelined restoring divider with saturated quotient
// One overflow check stage, then one quotient bit per stage. A quotient
// that does not fit (including a zero divisor) comes out as all ones.
// The whole pipeline moves on en; a side record travels along.
// ----------------------------------------------------------------------------
module wcts_div #(
    parameter int  DVD_W = 32,
    parameter int  DVS_W = 16,
    parameter int  Q_W   = 16,
    parameter type side_t = logic
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [DVS_W-1:0]   divisor,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [Q_W-1:0]     quotient,
    output side_t              out_side
);

    localparam int CW = (DVD_W > DVS_W + Q_W) ? DVD_W : DVS_W + Q_W;
    localparam int NS = Q_W + 1;

    logic               valid_reg [NS];
    logic [DVD_W-1:0]   rem_reg   [NS];
    logic [DVS_W-1:0]   dvs_reg   [NS];
    logic [Q_W-1:0]     q_reg     [NS];
    logic               sat_reg   [NS];
    side_t              side_reg  [NS];

    logic [CW-1:0]      trial     [1:Q_W];
    logic               ge        [1:Q_W];
    logic [DVD_W-1:0]   rem_next  [1:Q_W];
    logic [Q_W-1:0]     q_next    [1:Q_W];
    logic               sat_next;

    // Overflow check: dividend >= divisor * 2^Q_W
    assign sat_next = CW'(dividend) >= (CW'(divisor) << Q_W);

    // Trial subtract per quotient bit, MSB first
    always_comb
    begin
        for (int k = 1; k <= Q_W; k++)
        begin
            trial[k]    = CW'(dvs_reg[k-1]) << (Q_W - k);
            ge[k]       = CW'(rem_reg[k-1]) >= trial[k];
            rem_next[k] = ge[k] ? rem_reg[k-1] - trial[k][DVD_W-1:0] : rem_reg[k-1];
            q_next[k]   = q_reg[k-1] | (Q_W'(ge[k]) << (Q_W - k));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= dividend;
            dvs_reg[0]  <= divisor;
            q_reg[0]    <= '0;
            sat_reg[0]  <= sat_next;
            side_reg[0] <= in_side;
            for (int k = 1; k < NS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                dvs_reg[k]  <= dvs_reg[k-1];
                q_reg[k]    <= q_next[k];
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quotient  = q_reg[Q_W] | {Q_W{sat_reg[Q_W]}};
    assign out_side  = side_reg[Q_W];

endmodule

FILE: rtl/core/wcts_back.sv
// ----------------------------------------------------------------------------
// wcts_back: back end of the wall column texture setup
// Wall height divider, span and hit product stage, texture step divider,
// fraction and row product stage, then column and output register.
// Every stage moves together whenever the output register can take a beat.
// ----------------------------------------------------------------------------
module wcts_back import wcts_pkg::*; #(
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEFAULT,
    parameter int FRAC_BITS   = FRAC_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    input  front_item_t   pop_item,
    output logic          pop,
    wcts_wall_if.source   wall
);

    localparam int WH_DVD_W   = $clog2(SCREEN_ROWS + 1) + FRAC_BITS;
    localparam logic [WH_DVD_W-1:0] WH_DIVIDEND = WH_DVD_W'(SCREEN_ROWS) << FRAC_BITS;
    localparam int STEP_DVD_W = TEX_W + FRAC_BITS;
    localparam int HALF_W     = WH_W - 1;
    localparam int SPAN_W     = WH_W;
    localparam logic [SPAN_W-1:0] HALF_ROWS = SPAN_W'(SCREEN_ROWS / 2);
    localparam logic [SPAN_W-1:0] LAST_ROW  = SPAN_W'(SCREEN_ROWS - 1);
    localparam int PROD_RAW_W = DIST_W + 1 + DIR_W;
    localparam int PROD_W     = (PROD_RAW_W > 2 * FRAC_BITS) ? PROD_RAW_W : 2 * FRAC_BITS;
    localparam int ROWP_W     = HALF_W + STEP_W;
    localparam int COLP_W     = TEX_W + FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_SAT = '1;

    typedef struct packed {
        tex_sel_t                sel;
        logic [TEX_W-1:0]        tex_w;
        logic [TEX_W-1:0]        tex_h;
        logic [FRAC_BITS-1:0]    pos_frac;
        logic [FRAC_BITS-1:0]    prod_frac;
        logic [WH_W-1:0]         wh;
        logic [LINE_W-1:0]       ls;
        logic [LINE_W-1:0]       le;
        logic [HALF_W-1:0]       offset;
        logic                    zero;
    } span_t;

    typedef struct packed {
        tex_sel_t                sel;
        logic [TEX_W-1:0]        tex_w;
        logic [FRAC_BITS-1:0]    frac;
        logic [WH_W-1:0]         wh;
        logic [LINE_W-1:0]       ls;
        logic [LINE_W-1:0]       le;
        logic                    zero;
        logic [STEP_W-1:0]       step;
        logic [ROWP_W-1:0]       row_prod;
    } mix_t;

    logic                       en;
    logic                       wh_valid;
    logic [WH_W-1:0]            wh_q;
    front_item_t                wh_item;
    logic [HALF_W-1:0]          half_wh;
    logic [SPAN_W-1:0]          half_ext;
    logic [SPAN_W-1:0]          le_sum;
    logic                       over;
    logic signed [PROD_RAW_W-1:0] mult;
    logic signed [PROD_W-1:0]   prod;
    span_t                      span_next, span_reg;
    logic                       span_valid_reg;
    logic                       step_valid;
    logic [STEP_W-1:0]          step_q;
    span_t                      step_span;
    mix_t                       mix_next, mix_reg;
    logic                       mix_valid_reg;
    logic [COLP_W-1:0]          col_prod;
    logic [COL_W-1:0]           col_next;
    logic [STEP_W-1:0]          row_next;

    logic                       wall_valid_reg;
    tex_sel_t                   sel_reg;
    logic [COL_W-1:0]           col_reg;
    logic [WH_W-1:0]            wh_reg;
    logic [LINE_W-1:0]          ls_reg;
    logic [LINE_W-1:0]          le_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          row_reg;
    logic                       zero_reg;

    // Pipeline advance: output register empty or being drained
    assign en  = !wall_valid_reg || wall.ready;
    assign pop = en && pop_valid;

    // Wall height = SCREEN_ROWS * 2^FRAC_BITS / distance
    wcts_div #(
        .DVD_W  (WH_DVD_W),
        .DVS_W  (DIST_W),
        .Q_W    (WH_W),
        .side_t (front_item_t)
    ) u_wh_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pop_valid),
        .dividend  (WH_DIVIDEND),
        .divisor   (pop_item.depth),
        .in_side   (pop_item),
        .out_valid (wh_valid),
        .quotient  (wh_q),
        .out_side  (wh_item)
    );

    // Span on screen, row offset and hit product
    always_comb
    begin
        half_wh  = wh_q[WH_W-1:1];
        half_ext = SPAN_W'(half_wh);
        over     = half_ext > HALF_ROWS;
        le_sum   = HALF_ROWS + half_ext;
        mult     = $signed({1'b0, wh_item.depth}) * $signed(wh_item.dir);
        prod     = PROD_W'(mult);

        span_next.sel       = wh_item.sel;
        span_next.tex_w     = wh_item.tex_w;
        span_next.tex_h     = wh_item.tex_h;
        span_next.pos_frac  = wh_item.pos[FRAC_BITS-1:0];
        span_next.prod_frac = prod[2*FRAC_BITS-1:FRAC_BITS];
        span_next.wh        = wh_q;
        span_next.ls        = over ? '0 : LINE_W'(HALF_ROWS - half_ext);
        span_next.le        = (le_sum > LAST_ROW) ? LINE_W'(LAST_ROW) : LINE_W'(le_sum);
        span_next.offset    = over ? HALF_W'(half_ext - HALF_ROWS) : '0;
        span_next.zero      = (wh_q == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_valid_reg <= 1'b0;
        else if (en)
            span_valid_reg <= wh_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            span_reg <= span_next;
    end

    // Texture step = height * 2^FRAC_BITS / wall height
    wcts_div #(
        .DVD_W  (STEP_DVD_W),
        .DVS_W  (WH_W),
        .Q_W    (STEP_W),
        .side_t (span_t)
    ) u_step_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (span_valid_reg),
        .dividend  ({span_reg.tex_h, {FRAC_BITS{1'b0}}}),
        .divisor   (span_reg.wh),
        .in_side   (span_reg),
        .out_valid (step_valid),
        .quotient  (step_q),
        .out_side  (step_span)
    );

    // Hit fraction and start row product
    always_comb
    begin
        mix_next.sel      = step_span.sel;
        mix_next.tex_w    = step_span.tex_w;
        mix_next.frac     = step_span.pos_frac + step_span.prod_frac;
        mix_next.wh       = step_span.wh;
        mix_next.ls       = step_span.ls;
        mix_next.le       = step_span.le;
        mix_next.zero     = step_span.zero;
        mix_next.step     = step_q;
        mix_next.row_prod = ROWP_W'(step_span.offset) * ROWP_W'(step_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mix_valid_reg <= 1'b0;
        else if (en)
            mix_valid_reg <= step_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mix_reg <= mix_next;
    end

    // Texture column and saturated start row
    always_comb
    begin
        col_prod = COLP_W'(mix_reg.tex_w) * COLP_W'(mix_reg.frac);
        col_next = col_prod[FRAC_BITS+COL_W-1:FRAC_BITS];
        row_next = (mix_reg.row_prod > ROWP_W'(STEP_SAT)) ? STEP_SAT
                                                          : mix_reg.row_prod[STEP_W-1:0];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wall_valid_reg <= 1'b0;
        else if (en)
            wall_valid_reg <= mix_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg  <= mix_reg.sel;
            col_reg  <= col_next;
            wh_reg   <= mix_reg.wh;
            ls_reg   <= mix_reg.ls;
            le_reg   <= mix_reg.le;
            step_reg <= mix_reg.step;
            row_reg  <= row_next;
            zero_reg <= mix_reg.zero;
        end
    end

    assign wall.valid          = wall_valid_reg;
    assign wall.texture_select = sel_reg;
    assign wall.tex_column     = col_reg;
    assign wall.column_height  = wh_reg;
    assign wall.span_top       = ls_reg;
    assign wall.span_bottom    = le_reg;
    assign wall.texel_step     = step_reg;
    assign wall.tex_row_start  = row_reg;
    assign wall.zero_height    = zero_reg;

endmodule

FILE: rtl/core/wall_column_texture_setup_top.sv
// ----------------------------------------------------------------------------
// wall_column_texture_setup_top: textured wall column setup for a raycaster
// Usage:
// - ray: one beat per screen column (hit side, step signs, player position,
//   ray direction, perpendicular distance); wall: one result beat per ray
//   beat, in order (texture, column, height, span, step, start row).
// - cfg: eight texture size registers, always ready; write them only while
//   no column is in flight.
// - Throughput: one column per clock while the wall sink does not stall. The
//   path runs through the two bit-per-stage dividers (17 stages for wall
//   height, 29 for texture step) plus five registers.
// - Reset clears every valid bit and the queue; all texture sizes go to 64.
// - When the wall sink stalls, the whole back end holds; the front holding
//   stage and a two-entry queue keep taking ray beats until they fill, after
//   which ray.ready drops. ray.ready never depends on wall.ready directly.
// ----------------------------------------------------------------------------
module wall_column_texture_setup_top import wcts_pkg::*; #(
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEFAULT,
    parameter int FRAC_BITS   = FRAC_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    wcts_ray_if.sink      ray,
    wcts_cfg_if.sink      cfg,
    wcts_wall_if.source   wall
);

    logic          push_valid;
    logic          push_ready;
    front_item_t   push_item;
    logic          pop_valid;
    logic          pop;
    front_item_t   pop_item;

    // Classification and texture registers
    wcts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ray        (ray),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decoupling queue
    wcts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    // Arithmetic pipeline and output register
    wcts_back #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .wall      (wall)
    );

    // A stalled result freezes the back end, so nothing leaves the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        wall.valid && !wall.ready |-> !pop)
        else $error("queue popped while result stalled");

    // Zero wall height forces a saturated step and a zero start row
    assert property (@(posedge clk) disable iff (!rst_n)
        wall.valid && wall.zero_height |->
            wall.tex_row_start == '0 && wall.texel_step == '1 && wall.column_height == '0)
        else $error("zero height result inconsistent");

    // Wall span stays ordered and on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        wall.valid |->
            wall.span_top <= wall.span_bottom && 32'(wall.span_bottom) < SCREEN_ROWS)
        else $error("wall span out of order or off screen");

endmodule
